// ----- rtl/core/tcp_pkg.sv -----
// Shared types, constants and helper functions of the text command parser.
// Used by the channel interfaces and by the parser top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcp_pkg;

   // Payload widths
   localparam int unsigned CHAR_WIDTH  = 8;
   localparam int unsigned CMD_WIDTH   = 4;
   localparam int unsigned NUM_WIDTH   = 16;
   localparam int unsigned WEEK_WIDTH  = 7;
   localparam int unsigned POS_WIDTH   = 4;
   localparam int unsigned NUM_COUNT   = 3;
   localparam int unsigned KW_COUNT    = 6;
   localparam int unsigned KW_MAX_LEN  = 5;
   localparam int unsigned WEEK_MIN_LEN = 8;

   // Magnitude limits for saturating decimal conversion
   localparam logic [NUM_WIDTH-1:0] MAG_LIMIT = 16'd32768;
   localparam logic [NUM_WIDTH-1:0] POS_MAX   = 16'd32767;

   // Decoded command codes
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_EMPTY     = 4'd0,
      CMD_TIME_SET  = 4'd1,
      CMD_ALARM_SET = 4'd2,
      CMD_DAY_LOAD  = 4'd3,
      CMD_DROP      = 4'd4,
      CMD_SERVO     = 4'd5,
      CMD_STEPPER   = 4'd6,
      CMD_STORE     = 4'd7,
      CMD_REJECT    = 4'd8
   } command_type;

   // Class picked by the first character
   typedef enum logic [2:0] {
      LEAD_NONE  = 3'd0,
      LEAD_TIME  = 3'd1,
      LEAD_ALARM = 3'd2,
      LEAD_WEEK  = 3'd3,
      LEAD_WORD  = 3'd4
   } lead_type;

   // Number scanner phase within the current number
   typedef enum logic [2:0] {
      SCAN_SPACE = 3'd0,
      SCAN_SIGN  = 3'd1,
      SCAN_DIGIT = 3'd2,
      SCAN_DONE  = 3'd3,
      SCAN_FAIL  = 3'd4
   } scan_type;

   // Running parse state of one string
   typedef struct packed {
      logic [POS_WIDTH-1:0]                  pos;
      lead_type                              lead;
      logic [KW_COUNT-1:0]                   kw_alive;
      logic [1:0]                            scan_idx;
      scan_type                              scan;
      logic [NUM_COUNT-1:0][NUM_WIDTH-1:0]   num;
      logic                                  neg;
      logic [WEEK_WIDTH-1:0]                 week_bits;
      logic                                  week_valid;
      logic                                  ended;
   } parse_state_type;

   // Keywords, left aligned, zero padded
   localparam logic [8*KW_MAX_LEN-1:0] KW_WORD [KW_COUNT] = '{
      {"f", 32'h0},
      {"F", 32'h0},
      "servo",
      {"step", 8'h0},
      {"s", 32'h0},
      "store"
   };
   localparam logic [POS_WIDTH-1:0] KW_LEN [KW_COUNT] = '{
      4'd1, 4'd1, 4'd5, 4'd4, 4'd1, 4'd5
   };
   localparam command_type KW_CMD [KW_COUNT] = '{
      CMD_DROP, CMD_DROP, CMD_SERVO, CMD_STEPPER, CMD_STEPPER, CMD_STORE
   };

   // Character of keyword j at position p; zero beyond the keyword end
   function automatic logic [CHAR_WIDTH-1:0] kw_char(input logic [2:0] j,
                                                     input logic [POS_WIDTH-1:0] p);
      logic [8*KW_MAX_LEN-1:0] word;
      logic [2:0]              idx;
      word = KW_WORD[j];
      idx  = p[2:0];
      if (p >= KW_LEN[j]) begin
         return '0;
      end
      return word[8*KW_MAX_LEN-1 - 8*idx -: 8];
   endfunction

   function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // Turn a saturated magnitude into a signed 16-bit value
   function automatic logic [NUM_WIDTH-1:0] finalize(input logic [NUM_WIDTH-1:0] mag,
                                                     input logic neg);
      if (neg) begin
         return NUM_WIDTH'(16'd0 - mag);
      end
      return (mag > POS_MAX) ? POS_MAX : mag;
   endfunction

   // Append one decimal digit to a magnitude, saturating at the limit
   function automatic logic [NUM_WIDTH-1:0] add_digit(input logic [NUM_WIDTH-1:0] mag,
                                                      input logic [3:0] d);
      logic [NUM_WIDTH+3:0] acc;
      acc = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {16'd0, d};
      return (acc > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : acc[NUM_WIDTH-1:0];
   endfunction

   // State of an idle parser
   function automatic parse_state_type parse_reset();
      parse_state_type s;
      s.pos        = '0;
      s.lead       = LEAD_NONE;
      s.kw_alive   = '1;
      s.scan_idx   = '0;
      s.scan       = SCAN_SPACE;
      s.num        = '0;
      s.neg        = 1'b0;
      s.week_bits  = '0;
      s.week_valid = 1'b1;
      s.ended      = 1'b0;
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tcp_req_if.sv -----
// Request channel of the text command parser: one character per request.
// Depends on tcp_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcp_req_if;
   logic                             valid;
   logic                             ready;
   logic [tcp_pkg::CHAR_WIDTH-1:0]   char_byte;
   logic                             last;

   modport source (output valid, output char_byte, output last, input ready);
   modport sink   (input valid, input char_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tcp_rsp_if.sv -----
// Response channel of the text command parser: one decoded command per string.
// Depends on tcp_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [tcp_pkg::CMD_WIDTH-1:0]          command;
   logic signed [tcp_pkg::NUM_WIDTH-1:0]   hours;
   logic signed [tcp_pkg::NUM_WIDTH-1:0]   minutes;
   logic signed [tcp_pkg::NUM_WIDTH-1:0]   seconds;
   logic [tcp_pkg::WEEK_WIDTH-1:0]         week_days;

   modport source (output valid, output command, output hours, output minutes,
                   output seconds, output week_days, input ready);
   modport sink   (input valid, input command, input hours, input minutes,
                   input seconds, input week_days, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/text_command_parser_unit.sv -----
// Top level of the text command parser: request register, parse state, response register.
// Depends on tcp_pkg, tcp_req_if and tcp_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one character per request and answers with one decoded
// command on the request flagged last. It accepts a character every cycle
// while no last character is held back: a request register feeds the
// per-character state update and the result decode, and a response register
// holds the answer, loaded when the last character leaves the request register.
// A pending response that is not taken only blocks the next last character;
// plain characters keep flowing into the parse state. After each response the
// parse state returns to its idle value, ready for the next string.
module text_command_parser_unit (
   input  wire         clock,
   input  wire         reset,
   tcp_req_if.sink     req_chan,
   tcp_rsp_if.source   rsp_chan
);

   // Request register
   logic                             in_valid_ff, in_valid_in;
   logic [tcp_pkg::CHAR_WIDTH-1:0]   in_byte_ff;
   logic                             in_last_ff;
   logic                             req_take;
   logic                             advance;

   // Parse state
   tcp_pkg::parse_state_type         state_ff, state_in, state_upd;

   // Response register
   logic                             rsp_valid_ff, rsp_valid_in;
   tcp_pkg::command_type             cmd_ff, cmd_in;
   logic [tcp_pkg::NUM_WIDTH-1:0]    hours_ff, hours_in;
   logic [tcp_pkg::NUM_WIDTH-1:0]    minutes_ff, minutes_in;
   logic [tcp_pkg::NUM_WIDTH-1:0]    seconds_ff, seconds_in;
   logic [tcp_pkg::WEEK_WIDTH-1:0]   week_ff, week_in;

   // Decode helpers
   logic [tcp_pkg::CHAR_WIDTH-1:0]   c;
   logic [tcp_pkg::POS_WIDTH-1:0]    p;
   logic [1:0]                       k;
   logic [3:0]                       digit;
   logic [tcp_pkg::NUM_COUNT-1:0][tcp_pkg::NUM_WIDTH-1:0] num_out;
   logic                             nums_done;
   logic                             kw_hit;

   // Handshake: the request register advances unless a response would be overwritten
   assign advance      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take     = req_chan.valid && req_chan.ready;
   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_chan.char_byte;
         in_last_ff <= req_chan.last;
      end
   end

   // Next parse state: fold one character into the running state
   always_comb begin
      state_upd = state_ff;
      c         = in_byte_ff;
      p         = state_ff.pos;
      k         = state_ff.scan_idx;
      digit     = in_byte_ff[3:0];
      if (in_valid_ff && !state_ff.ended) begin
         if (c == '0) begin
            state_upd.ended = 1'b1;
         end else begin
            // drop keywords that no longer match
            for (int j = 0; j < tcp_pkg::KW_COUNT; j++) begin
               if (tcp_pkg::kw_char(3'(j), p) != c) begin
                  state_upd.kw_alive[j] = 1'b0;
               end
            end
            if (p == '0) begin
               if (c == "T" || c == "t") begin
                  state_upd.lead = tcp_pkg::LEAD_TIME;
               end else if (c == "A" || c == "a") begin
                  state_upd.lead = tcp_pkg::LEAD_ALARM;
               end else if (c == "L" || c == "l") begin
                  state_upd.lead = tcp_pkg::LEAD_WEEK;
               end else begin
                  state_upd.lead = tcp_pkg::LEAD_WORD;
               end
            end else if (state_ff.lead == tcp_pkg::LEAD_TIME ||
                         state_ff.lead == tcp_pkg::LEAD_ALARM) begin
               // number scanner, "%d:%d:%d"
               case (state_ff.scan)
                  tcp_pkg::SCAN_SPACE: begin
                     if (tcp_pkg::is_space(c)) begin
                        state_upd.scan = tcp_pkg::SCAN_SPACE;
                     end else if (c == "+" || c == "-") begin
                        state_upd.neg    = (c == "-");
                        state_upd.num[k] = '0;
                        state_upd.scan   = tcp_pkg::SCAN_SIGN;
                     end else if (tcp_pkg::is_digit(c)) begin
                        state_upd.neg    = 1'b0;
                        state_upd.num[k] = {12'd0, digit};
                        state_upd.scan   = tcp_pkg::SCAN_DIGIT;
                     end else begin
                        state_upd.scan   = tcp_pkg::SCAN_FAIL;
                     end
                  end
                  tcp_pkg::SCAN_SIGN: begin
                     if (tcp_pkg::is_digit(c)) begin
                        state_upd.num[k] = {12'd0, digit};
                        state_upd.scan   = tcp_pkg::SCAN_DIGIT;
                     end else begin
                        state_upd.scan   = tcp_pkg::SCAN_FAIL;
                     end
                  end
                  tcp_pkg::SCAN_DIGIT: begin
                     if (tcp_pkg::is_digit(c)) begin
                        state_upd.num[k] = tcp_pkg::add_digit(state_ff.num[k], digit);
                     end else begin
                        state_upd.num[k] = tcp_pkg::finalize(state_ff.num[k], state_ff.neg);
                        if (k == 2'd2) begin
                           state_upd.scan = tcp_pkg::SCAN_DONE;
                        end else if (c == ":") begin
                           state_upd.scan_idx = k + 2'd1;
                           state_upd.scan     = tcp_pkg::SCAN_SPACE;
                        end else begin
                           state_upd.scan = tcp_pkg::SCAN_FAIL;
                        end
                     end
                  end
                  default: begin
                     state_upd.scan = state_ff.scan;
                  end
               endcase
            end else if (state_ff.lead == tcp_pkg::LEAD_WEEK && p <= 4'd7) begin
               // day flags, first flag in bit 0
               if (c == "1") begin
                  state_upd.week_bits[3'(p - 4'd1)] = 1'b1;
               end else if (c != "0") begin
                  state_upd.week_valid = 1'b0;
               end
            end
            if (p != '1) begin
               state_upd.pos = p + 4'd1;
            end
         end
      end
   end

   // Hold the state while stalled; return to idle after the last character
   always_comb begin
      if (advance) begin
         state_in = in_last_ff ? tcp_pkg::parse_reset() : state_upd;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcp_pkg::parse_reset();
      end else begin
         state_ff <= state_in;
      end
   end

   // Result decode from the updated state
   always_comb begin
      num_out   = state_upd.num;
      nums_done = (state_upd.scan == tcp_pkg::SCAN_DONE);
      kw_hit    = 1'b0;
      cmd_in    = tcp_pkg::CMD_EMPTY;
      hours_in  = '0;
      minutes_in = '0;
      seconds_in = '0;
      week_in   = '0;
      // a number still in its digits ends with the string
      if (state_upd.scan == tcp_pkg::SCAN_DIGIT) begin
         num_out[state_upd.scan_idx] =
            tcp_pkg::finalize(state_upd.num[state_upd.scan_idx], state_upd.neg);
         nums_done = (state_upd.scan_idx == 2'd2);
      end
      case (state_upd.lead)
         tcp_pkg::LEAD_TIME, tcp_pkg::LEAD_ALARM: begin
            if (nums_done) begin
               cmd_in = (state_upd.lead == tcp_pkg::LEAD_TIME) ?
                        tcp_pkg::CMD_TIME_SET : tcp_pkg::CMD_ALARM_SET;
            end else begin
               cmd_in = tcp_pkg::CMD_REJECT;
            end
            hours_in   = num_out[0];
            minutes_in = num_out[1];
            seconds_in = num_out[2];
         end
         tcp_pkg::LEAD_WEEK: begin
            if (state_upd.pos >= 4'(tcp_pkg::WEEK_MIN_LEN) && state_upd.week_valid) begin
               cmd_in  = tcp_pkg::CMD_DAY_LOAD;
               week_in = state_upd.week_bits;
            end else begin
               cmd_in  = tcp_pkg::CMD_REJECT;
            end
         end
         tcp_pkg::LEAD_WORD: begin
            cmd_in = tcp_pkg::CMD_REJECT;
            // first matching keyword wins
            for (int j = 0; j < tcp_pkg::KW_COUNT; j++) begin
               if (!kw_hit && state_upd.kw_alive[j] &&
                   state_upd.pos == tcp_pkg::KW_LEN[j]) begin
                  kw_hit = 1'b1;
                  cmd_in = tcp_pkg::KW_CMD[j];
               end
            end
         end
         default: begin
            cmd_in = tcp_pkg::CMD_EMPTY;
         end
      endcase
   end

   // Response register: load on the last character, drop when taken
   assign rsp_valid_in = (advance && in_last_ff) ? 1'b1 :
                         (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && in_last_ff) begin
         cmd_ff     <= cmd_in;
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         week_ff    <= week_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.command   = cmd_ff;
   assign rsp_chan.hours     = hours_ff;
   assign rsp_chan.minutes   = minutes_ff;
   assign rsp_chan.seconds   = seconds_ff;
   assign rsp_chan.week_days = week_ff;

   // Parse state is idle right after a string is closed
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=>
         (state_ff.pos == '0 && state_ff.lead == tcp_pkg::LEAD_NONE && !state_ff.ended))
      else $error("parse state not cleared after last character");

   // A held request is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("held request lost");

   // Day flags only travel with auto load
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && cmd_ff != tcp_pkg::CMD_DAY_LOAD) |-> (week_ff == '0))
      else $error("day flags on a command other than auto load");

   // Time fields only travel with time-led commands
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (cmd_ff == tcp_pkg::CMD_EMPTY || cmd_ff == tcp_pkg::CMD_DAY_LOAD ||
                        cmd_ff == tcp_pkg::CMD_DROP || cmd_ff == tcp_pkg::CMD_SERVO ||
                        cmd_ff == tcp_pkg::CMD_STEPPER || cmd_ff == tcp_pkg::CMD_STORE))
      |-> (hours_ff == '0 && minutes_ff == '0 && seconds_ff == '0))
      else $error("time fields on a command without numbers");

endmodule

`default_nettype wire
